@@ src/jlvi_pkg.sv @@
// ----------------------------------------------------------------------------
// jlvi_pkg
// Types and constants shared by the jerk-limited velocity interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package jlvi_pkg;

	localparam int ACC_REGS  = 7;
	localparam int DIV_STEPS = 30;

	// register indexes on the configuration port
	localparam logic [3:0] CFG_JERK_RATIO = 4'd7;

	localparam logic       REQ_SET  = 1'b0;
	localparam logic       REQ_TICK = 1'b1;

	// 1.0 in Q1.30
	localparam logic [30:0] T_ONE = 31'h4000_0000;

	localparam logic [30:0] ACC_RESET [ACC_REGS] = '{
		31'd491520, 31'd245760, 31'd327680, 31'd409600,
		31'd491520, 31'd655360, 31'd655360
	};
	localparam logic [15:0] JERK_RATIO_RESET = 16'd500;

	typedef struct packed {
		logic              req_type;
		logic [2:0]        joint_index;
		logic signed [31:0] target_velocity;
		logic [23:0]       period;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_joint;
		logic signed [31:0] velocity_command;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [30:0] bound;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [29:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT2,
		ST_ACC,
		ST_JA,
		ST_JR,
		ST_BND,
		ST_DIV,
		ST_DLT,
		ST_STEP,
		ST_CMD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

@@ src/jlvi_div.sv @@
// ----------------------------------------------------------------------------
// jlvi_div
// Restoring divider, one quotient bit per cycle: floor(bound * 2^30 / den),
// valid for bound < den.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvi_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jlvi_pkg::div_req_t req,
	output jlvi_pkg::div_rsp_t      rsp
);
	import jlvi_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [29:0] quo_q;
	logic [33:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[32:0], 1'b0};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {3'b0, req.bound};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[28:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

@@ src/jerk_limited_velocity_interpolator.sv @@
// ----------------------------------------------------------------------------
// jerk_limited_velocity_interpolator
// Per-joint velocity rate limiter with acceleration and jerk bounds and a
// shared interpolation factor across all joints.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | transaction
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | in_valid/in_stall | set target or tick (in_item_t)
//  out     | output    | out_valid/stall   | one joint command (out_item_t)
//  cfg     | input     | cfg_valid/ready   | register write, index + data
//
// A set transaction is taken without stalling the input. A tick runs a
// limit pass over all joints and then a command pass with one command per
// joint; the per-joint limit pass uses the one shared multiplier and the
// one-bit-per-cycle divider (the divider only when a joint must be slowed).
// in_stall is high from tick acceptance until the last command is taken.
// Each command waits in the output register while out_stall is high.
// Reset restores the register defaults and zeroes all joint state.
//
`default_nettype none

module jerk_limited_velocity_interpolator #(
	parameter int JOINTS = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire jlvi_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output jlvi_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [3:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import jlvi_pkg::*;

	localparam logic [2:0] LAST_J = 3'(JOINTS - 1);

	state_t state_q, state_d;

	// joint state
	logic signed [31:0] tgt_q  [JOINTS];
	logic signed [31:0] prev_q [JOINTS];
	logic signed [31:0] pp_q   [JOINTS];
	logic [30:0]        acc_q  [ACC_REGS];
	logic [15:0]        ratio_q;

	// tick working registers
	logic [2:0]  j_q;
	logic [23:0] dt_q;
	logic [23:0] dt2_q;
	logic [30:0] acc_step_q;
	logic [30:0] tmp_q;
	logic [45:0] jerk_q;
	logic [30:0] t_q;
	logic [32:0] ad_q;
	logic        neg_q;
	logic [32:0] step_q;
	out_item_t   out_q;

	// shared multiplier
	logic [32:0] mul_a;
	logic [30:0] mul_b;
	logic [63:0] mul_p;

	logic [2:0]  acc_sel;
	logic [30:0] acc_cur;

	// bound evaluation
	logic signed [32:0] ld, dl;
	logic signed [48:0] ub, lb, acc_s, jerk_s, ld_x;
	logic [32:0] ad;
	logic        blocked;
	logic [30:0] bound;
	logic        need_div;
	logic [32:0] cmd;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_acc, out_acc;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// joints past the last register share the last acceleration limit
	assign acc_sel = (j_q < 3'(ACC_REGS)) ? j_q : 3'(ACC_REGS - 1);
	assign acc_cur = acc_q[acc_sel];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DT2: begin
				mul_a = 33'(dt_q);
				mul_b = 31'(dt_q);
			end
			ST_ACC: begin
				mul_a = 33'(dt_q);
				mul_b = acc_cur;
			end
			ST_JA: begin
				mul_a = 33'(dt2_q);
				mul_b = acc_cur;
			end
			ST_JR: begin
				mul_a = 33'(tmp_q);
				mul_b = 31'(ratio_q);
			end
			ST_STEP: begin
				mul_a = ad_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {31'b0, mul_a} * {33'b0, mul_b};

	// upper/lower velocity change bounds for joint j_q
	always_comb begin
		ld     = {prev_q[j_q][31], prev_q[j_q]} - {pp_q[j_q][31], pp_q[j_q]};
		dl     = {tgt_q[j_q][31], tgt_q[j_q]} - {prev_q[j_q][31], prev_q[j_q]};
		ld_x   = {{16{ld[32]}}, ld};
		acc_s  = {18'b0, acc_step_q};
		jerk_s = {3'b0, jerk_q};
		ub     = ld_x + jerk_s;
		if (acc_s < ub) begin
			ub = acc_s;
		end
		lb = ld_x - jerk_s;
		if (-acc_s > lb) begin
			lb = -acc_s;
		end
		ad      = dl[32] ? 33'(-dl) : 33'(dl);
		blocked = (dl > 0 && ub <= 0) || (dl < 0 && lb >= 0);
		bound   = dl[32] ? 31'(-lb) : ub[30:0];
		need_div = (dl != 0) && !blocked && ({2'b0, bound} < ad);
	end

	assign cmd = neg_q ? {prev_q[j_q][31], prev_q[j_q]} - step_q
	                   : {prev_q[j_q][31], prev_q[j_q]} + step_q;

	assign div_req.start = (state_q == ST_BND) && need_div;
	assign div_req.bound = bound;
	assign div_req.den   = ad;

	jlvi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_data.req_type == REQ_TICK) begin
					state_d = ST_DT2;
				end
			end
			ST_DT2:  state_d = ST_ACC;
			ST_ACC:  state_d = ST_JA;
			ST_JA:   state_d = ST_JR;
			ST_JR:   state_d = ST_BND;
			ST_BND: begin
				if (need_div) begin
					state_d = ST_DIV;
				end else begin
					state_d = (j_q == LAST_J) ? ST_DLT : ST_ACC;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (j_q == LAST_J) ? ST_DLT : ST_ACC;
				end
			end
			ST_DLT:  state_d = ST_STEP;
			ST_STEP: state_d = ST_CMD;
			ST_CMD:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_acc) begin
					state_d = (j_q == LAST_J) ? ST_IDLE : ST_DLT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers and joint state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACC_REGS; i++) begin
				acc_q[i] <= ACC_RESET[i];
			end
			ratio_q <= JERK_RATIO_RESET;
			for (int i = 0; i < JOINTS; i++) begin
				tgt_q[i]  <= '0;
				prev_q[i] <= '0;
				pp_q[i]   <= '0;
			end
			j_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < 4'(ACC_REGS)) begin
					acc_q[cfg_index[2:0]] <= cfg_data[30:0];
				end else if (cfg_index == CFG_JERK_RATIO) begin
					ratio_q <= cfg_data[15:0];
				end
			end
			if (in_acc && in_data.req_type == REQ_SET
			    && {1'b0, in_data.joint_index} < 4'(JOINTS)) begin
				tgt_q[in_data.joint_index] <= in_data.target_velocity;
			end
			case (state_q)
				ST_DT2: j_q <= '0;
				ST_BND: begin
					if (!need_div) begin
						j_q <= (j_q == LAST_J) ? 3'd0 : j_q + 3'd1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						j_q <= (j_q == LAST_J) ? 3'd0 : j_q + 3'd1;
					end
				end
				ST_CMD: begin
					pp_q[j_q]   <= prev_q[j_q];
					prev_q[j_q] <= cmd[31:0];
				end
				ST_OUT: begin
					if (out_acc) begin
						j_q <= (j_q == LAST_J) ? 3'd0 : j_q + 3'd1;
					end
				end
				default: j_q <= j_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dt_q <= in_data.period;
				t_q  <= T_ONE;
			end
			ST_DT2: dt2_q      <= mul_p[47:24];
			ST_ACC: acc_step_q <= mul_p[54:24];
			ST_JA:  tmp_q      <= mul_p[54:24];
			ST_JR:  jerk_q     <= mul_p[46:1];
			ST_BND: begin
				if (blocked && dl != 0) begin
					t_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_rsp.done && {1'b0, div_rsp.quo} < t_q) begin
					t_q <= {1'b0, div_rsp.quo};
				end
			end
			ST_DLT: begin
				ad_q  <= ad;
				neg_q <= dl[32];
			end
			ST_STEP: step_q <= mul_p[62:30];
			ST_CMD: begin
				out_q.out_joint        <= j_q;
				out_q.velocity_command <= cmd[31:0];
				out_q.last             <= (j_q == LAST_J);
			end
			default: dt_q <= dt_q;
		endcase
	end

endmodule

`default_nettype wire

@@ src/jlvi_chk.sv @@
// ----------------------------------------------------------------------------
// jlvi_chk
// Port-level checks for the velocity interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvi_chk (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire jlvi_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire jlvi_pkg::out_item_t out_data
);
	import jlvi_pkg::*;

	// held command stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// no command outside a tick
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("command while input open");

	// a tick blocks the input
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_TICK |=> in_stall)
		else $error("tick did not start");

	// a set never blocks
	a_set_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_SET |=> !in_stall)
		else $error("set stalled input");

	// last command ends the tick
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last |=> !in_stall && !out_valid)
		else $error("tick did not end on last");

endmodule

bind jerk_limited_velocity_interpolator jlvi_chk u_jlvi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

@@ bench/jlvi_checker.sv @@
// ----------------------------------------------------------------------------
// jlvi_checker
// Watches the input, output and register channels of the interpolator,
// predicts the joint commands of every tick and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvi_checker #(
	parameter int JOINTS = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire jlvi_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire jlvi_pkg::out_item_t out_data,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [3:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	output int                       errors,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import jlvi_pkg::*;

	logic [30:0]        acc_lim [ACC_REGS];
	logic [15:0]        jerk_mul;
	logic signed [63:0] goal [JOINTS];
	logic signed [63:0] cmd_now [JOINTS];
	logic signed [63:0] cmd_old [JOINTS];
	out_item_t          cmd_queue [$];

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// one tick: shared fraction across joints, then interpolate each joint
	task automatic predict_tick(input logic [23:0] dt);
		logic [63:0]        dt2, t, acc, bound, ad, tj, step;
		logic signed [63:0] acc_step, jerk_term, last_d, delta, ub, lb, cmd;
		out_item_t          o;
		dt2 = (64'(dt) * 64'(dt)) >> 24;
		t = 64'd1 << 30;
		for (int j = 0; j < JOINTS; j++) begin
			acc = 64'(acc_lim[j < ACC_REGS ? j : ACC_REGS - 1]);
			acc_step = (64'(dt) * acc) >> 24;
			jerk_term = (((dt2 * acc) >> 24) * 64'(jerk_mul)) >> 1;
			last_d = cmd_now[j] - cmd_old[j];
			delta = goal[j] - cmd_now[j];
			ub = last_d + jerk_term;
			lb = last_d - jerk_term;
			if (acc_step < ub) ub = acc_step;
			if (-acc_step > lb) lb = -acc_step;
			if (delta == 0) continue;
			if (delta > 0) begin
				if (ub <= 0) begin t = 0; continue; end
				bound = ub;
			end else begin
				if (lb >= 0) begin t = 0; continue; end
				bound = abs64(lb);
			end
			ad = abs64(delta);
			tj = (bound >= ad) ? (64'd1 << 30) : (bound << 30) / ad;
			if (tj < t) t = tj;
		end
		for (int j = 0; j < JOINTS; j++) begin
			delta = goal[j] - cmd_now[j];
			step = (abs64(delta) * t) >> 30;
			cmd = delta < 0 ? cmd_now[j] - $signed(step) : cmd_now[j] + $signed(step);
			cmd_old[j] = cmd_now[j];
			cmd_now[j] = cmd;
			o.out_joint = 3'(j);
			o.velocity_command = cmd[31:0];
			o.last = (j == JOINTS - 1);
			cmd_queue = {cmd_queue, o};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_o;
		if (!arst_n) begin
			for (int i = 0; i < ACC_REGS; i++) acc_lim[i] = ACC_RESET[i];
			jerk_mul = JERK_RATIO_RESET;
			for (int j = 0; j < JOINTS; j++) begin
				goal[j] = 0; cmd_now[j] = 0; cmd_old[j] = 0;
			end
			cmd_queue.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < CFG_JERK_RATIO) acc_lim[cfg_index[2:0]] = cfg_data[30:0];
				else if (cfg_index == CFG_JERK_RATIO) jerk_mul = cfg_data[15:0];
			end
			if (out_valid && !out_stall) begin
				if (cmd_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected command %p", $time, out_data);
				end else begin
					exp_o = cmd_queue.pop_front();
					if (out_data.out_joint !== exp_o.out_joint) begin
						errors++;
						$display("%0t: out_joint expected %0d actual %0d", $time,
							exp_o.out_joint, out_data.out_joint);
					end
					if (out_data.velocity_command !== exp_o.velocity_command) begin
						errors++;
						$display("%0t: velocity_command expected %0d actual %0d", $time,
							exp_o.velocity_command, out_data.velocity_command);
					end
					if (out_data.last !== exp_o.last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b", $time,
							exp_o.last, out_data.last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.req_type == REQ_TICK) predict_tick(in_data.period);
				else if (in_data.joint_index < JOINTS)
					goal[in_data.joint_index] = 64'(in_data.target_velocity);
			end
		end
		pending = cmd_queue.size();
	end

endmodule

`default_nettype wire

@@ bench/tb_jerk_limited_velocity_interpolator.sv @@
// ----------------------------------------------------------------------------
// tb_jerk_limited_velocity_interpolator
// Drives set and tick transactions with random gaps and output stalls,
// reprograms the acceleration and jerk registers between phases, and
// leaves the checking to jlvi_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_jerk_limited_velocity_interpolator;
	timeunit 1ns;
	timeprecision 1ps;
	import jlvi_pkg::*;

	localparam int  JOINTS      = 7;
	localparam int  TIMEOUT_CYC = 2_000_000;
	localparam int  DRAIN_CYC   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          errors, pending;
	int          cycles = 0;
	bit          hold_out = 1'b0;   // long receiver hold-off request
	bit          quiet_out = 1'b0;  // no random stall during this phase

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	jerk_limited_velocity_interpolator #(.JOINTS(JOINTS)) u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid,
		.out_stall, .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	jlvi_checker #(.JOINTS(JOINTS)) u_chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid,
		.out_stall, .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYC) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: per command a random stall length, or a long hold when asked
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (600) @(negedge clk);
				hold_out = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n = quiet_out ? 0 : $urandom_range(0, 13);
				if ($urandom_range(0, 3) == 0) n = 0;
				out_stall <= (n != 0);
				if (n != 0) begin
					repeat (n - 1) @(negedge clk);
					out_stall <= 1'b0;
				end
				// hold off stalls until a command has been taken
				do @(posedge clk); while (!(out_valid && !out_stall));
			end
		end
	end

	// one input transaction, with a random gap ahead of it; returns at the
	// falling edge after acceptance with valid still high, so the next call
	// (or drain) decides what valid does there
	task automatic send(input in_item_t item, input bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 13) : 0;
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_goal(input logic [2:0] j, input logic [31:0] v, input bit gaps);
		in_item_t it;
		it = '0;
		it.req_type = REQ_SET;
		it.joint_index = j;
		it.target_velocity = v;
		it.period = 24'($urandom);
		send(it, gaps);
	endtask

	task automatic tick(input logic [23:0] dt, input bit gaps);
		in_item_t it;
		it = '0;
		it.req_type = REQ_TICK;
		it.joint_index = 3'($urandom);
		it.target_velocity = $urandom;
		it.period = dt;
		send(it, gaps);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender pause until every expected command is back, plus latency margin
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// random velocity: modest in half the cases, else full range or an extreme
	function automatic logic [31:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	function automatic logic [23:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return 24'hFF_FFFF;
			1: return 24'd1;
			2: return 24'($urandom);
			default: return 24'($urandom_range(8000, 40000)); // about 0.5 to 2.4 ms
		endcase
	endfunction

	task automatic random_phase(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 2) == 0) tick(rand_dt(), 1'b1);
			else set_goal(3'($urandom_range(0, 7)), rand_vel(), 1'b1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers, extremes, both blocked directions
		quiet_out = 1'b1;
		tick(24'd16777, 1'b0);                 // all zero, no move
		set_goal(3'd0, 32'h7FFF_FFFF, 1'b0);
		set_goal(3'd6, 32'h8000_0000, 1'b0);
		set_goal(3'd7, 32'h1234_5678, 1'b0);   // out of range joint, ignored
		tick(24'd0, 1'b0);                     // zero period blocks the move
		tick(24'hFF_FFFF, 1'b0);
		tick(24'd1, 1'b0);
		set_goal(3'd3, 32'h0001_0000, 1'b0);
		tick(24'd16777, 1'b0);
		set_goal(3'd0, 32'h0000_0000, 1'b0);   // reverse after acceleration
		tick(24'd16777, 1'b0);
		tick(24'd16777, 1'b0);
		quiet_out = 1'b0;
		drain();

		// extremes of the registers
		for (int i = 0; i < ACC_REGS; i++) write_reg(4'(i), 32'h7FFF_FFFF);
		write_reg(CFG_JERK_RATIO, 32'h0000_FFFF);
		for (int j = 0; j < JOINTS; j++) set_goal(3'(j), rand_vel(), 1'b0);
		tick(24'hFF_FFFF, 1'b0);
		tick(24'd16777, 1'b0);
		drain();
		for (int i = 0; i < ACC_REGS; i++) write_reg(4'(i), 32'h0);
		write_reg(CFG_JERK_RATIO, 32'd1);
		write_reg(4'd15, 32'hFFFF_FFFF);       // unknown index, ignored
		random_phase(30);
		drain();

		// long receiver hold while the sender keeps offering
		hold_out = 1'b1;
		random_phase(40);
		drain();

		// several random settings
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < ACC_REGS; i++)
				write_reg(4'(i), ($urandom_range(0, 3) == 0) ? $urandom
					: 32'($urandom_range(1 << 16, 20 << 16)));
			write_reg(CFG_JERK_RATIO, ($urandom_range(0, 3) == 0) ? $urandom
				: 32'($urandom_range(1, 2000)));
			random_phase(70);
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
